/* rtl/rtpm_pkg.sv */
// Package for the route table prefix match block.
// Holds table sizing, entry layout, request/status codes and sequencer states.
// No dependencies.
package rtpm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic        prot;
    logic        valid;
    logic [31:0] hop;
    logic [31:0] mask;
    logic [31:0] prefix;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_DEL    = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOTFOUND  = 2'd1,
    ST_PROTECTED = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DIRECT = 2'd1,
    KIND_HOP    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  // Compare results for one table entry against the held request
  typedef struct packed {
    logic free;
    logic exact;
    logic hit;
    logic wider;
  } cmp_t;

endpackage

/* rtl/rtpm_if.sv */
// Request and response channel interfaces for the route table block.
// Valid/ready handshake; no package dependency.
interface rtpm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] address;
  logic [31:0] prefix_mask;
  logic [31:0] next_hop_in;
  logic        protect_entry;

  modport source (output valid, req_type, address, prefix_mask, next_hop_in,
                  protect_entry, input ready);
  modport sink   (input valid, req_type, address, prefix_mask, next_hop_in,
                  protect_entry, output ready);
endinterface

interface rtpm_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  route_kind;
  logic [31:0] next_hop;

  modport source (output valid, status, route_kind, next_hop, input ready);
  modport sink   (input valid, status, route_kind, next_hop, output ready);
endinterface

/* rtl/rtpm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rtpm_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/rtpm_cmp.sv */
// Shared compare unit: checks one table entry against the held request.
// Depends on rtpm_pkg.
module rtpm_cmp (
  input  rtpm_pkg::entry_t entry,
  input  logic [31:0]      address,
  input  logic [31:0]      mask,
  input  logic [31:0]      hop,
  input  logic [31:0]      best_mask,
  output rtpm_pkg::cmp_t   res
);
  import rtpm_pkg::*;

  always_comb begin
    res.free  = !entry.valid;
    res.exact = entry.valid && entry.prefix == address && entry.mask == mask &&
                entry.hop == hop;
    res.hit   = entry.valid && (address & entry.mask) == entry.prefix;
    res.wider = entry.mask > best_mask;
  end

endmodule

/* rtl/route_table_prefix_match_top.sv */
// Top level of the route table with longest-prefix lookup.
// Depends on rtpm_pkg, rtpm_if, rtpm_ram and rtpm_cmp.
//
//   channel  direction  fields
//   req      in         req_type, address, prefix_mask, next_hop_in, protect_entry
//   rsp      out        status, route_kind, next_hop
//
// Every request scans all TABLE_DEPTH slots through one RAM read port and one
// compare unit: it is taken only in the idle state, the scan state issues the
// TABLE_DEPTH reads and compares the registered read data as it returns, and the
// finish state writes the table and registers the response.
// After reset a clearing pass writes every slot with ready low.
// The finish cycle waits while an earlier response has not been taken.
module route_table_prefix_match_top (
  input logic       clk,
  input logic       rst,
  rtpm_req_if.sink  req,
  rtpm_rsp_if.source rsp
);
  import rtpm_pkg::*;

  state_t state, state_next;

  logic [CNT_W-1:0] cnt;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;

  logic [1:0]  req_kind;
  logic [31:0] req_addr;
  logic [31:0] req_mask;
  logic [31:0] req_hop;
  logic        req_prot;

  logic             found;
  logic [IDX_W-1:0] best_idx;
  logic             best_prot;
  logic [31:0]      best_mask;
  logic [31:0]      best_hop;

  logic        rsp_valid;
  logic [1:0]  rsp_status;
  logic [1:0]  rsp_kind;
  logic [31:0] rsp_hop;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;
  cmp_t             cmp;

  logic accept;
  logic scan_done;
  logic fin_go;

  assign accept    = req.valid && req.ready;
  assign scan_done = state == S_SCAN && cnt == CNT_W'(TABLE_DEPTH) && !rd_vld;
  assign fin_go    = state == S_FIN && (!rsp_valid || rsp.ready);

  rtpm_ram #(
    .DEPTH(TABLE_DEPTH),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  rtpm_cmp u_cmp (
    .entry    (ram_rdata),
    .address  (req_addr),
    .mask     (req_mask),
    .hop      (req_hop),
    .best_mask(best_mask),
    .res      (cmp)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (cnt == CNT_W'(TABLE_DEPTH - 1)) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_SCAN;
      S_SCAN:  if (scan_done) state_next = S_FIN;
      S_FIN:   if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    req.ready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = best_idx;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = cnt[IDX_W-1:0];
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[IDX_W-1:0];
      end
      S_IDLE: begin
        req.ready = 1'b1;
      end
      S_SCAN: begin
        ram_re = cnt < CNT_W'(TABLE_DEPTH);
      end
      S_FIN: begin
        if (fin_go && found) begin
          case (req_kind)
            REQ_ADD: begin
              ram_we    = 1'b1;
              ram_wdata = '{prot: req_prot, valid: 1'b1, hop: req_hop,
                            mask: req_mask, prefix: req_addr};
            end
            REQ_DEL: begin
              // clear the slot unless protected
              ram_we = !best_prot;
            end
            default: ram_we = 1'b0;
          endcase
        end
      end
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        cnt <= '0;
      end else if ((state == S_CLEAR || state == S_SCAN) &&
                   cnt < CNT_W'(TABLE_DEPTH)) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Hold request fields for the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= req.req_type;
      req_addr <= req.address;
      req_mask <= req.prefix_mask;
      req_hop  <= req.next_hop_in;
      req_prot <= req.protect_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else if (accept) begin
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else begin
      rd_vld <= ram_re;
      if (rd_vld) begin
        case (req_kind)
          REQ_ADD:    if (cmp.free && !found) found <= 1'b1;
          REQ_DEL:    if (cmp.exact && !found) found <= 1'b1;
          REQ_LOOKUP: if (cmp.hit) found <= 1'b1;
          default:    found <= found;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= ram_raddr;
    if (rd_vld) begin
      case (req_kind)
        REQ_ADD: begin
          if (cmp.free && !found) best_idx <= rd_idx;
        end
        REQ_DEL: begin
          if (cmp.exact && !found) begin
            best_idx  <= rd_idx;
            best_prot <= ram_rdata.prot;
          end
        end
        REQ_LOOKUP: begin
          // keep the first of equal masks
          if (cmp.hit && (!found || cmp.wider)) begin
            best_idx  <= rd_idx;
            best_mask <= ram_rdata.mask;
            best_hop  <= ram_rdata.hop;
          end
        end
        default: best_idx <= best_idx;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fin_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      rsp_status <= ST_OK;
      rsp_kind   <= KIND_NONE;
      rsp_hop    <= '0;
      case (req_kind)
        REQ_ADD: begin
          if (!found) rsp_status <= ST_FULL;
        end
        REQ_DEL: begin
          if (!found) begin
            rsp_status <= ST_NOTFOUND;
          end else if (best_prot) begin
            rsp_status <= ST_PROTECTED;
          end
        end
        REQ_LOOKUP: begin
          if (!found) begin
            rsp_status <= ST_NOTFOUND;
          end else if (best_hop == '0) begin
            rsp_kind <= KIND_DIRECT;
          end else begin
            rsp_kind <= KIND_HOP;
            rsp_hop  <= best_hop;
          end
        end
        default: rsp_status <= ST_OK;
      endcase
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_status;
  assign rsp.route_kind = rsp_kind;
  assign rsp.next_hop   = rsp_hop;

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req.ready)
    else $error("request taken during clearing pass");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SCAN && cnt == '0)
    else $error("accepted transaction did not start a scan");

  a_write_when_allowed: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || fin_go))
    else $error("table write outside clear or finish");

  a_finish_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    fin_go |=> rsp_valid && state == S_IDLE)
    else $error("finished request produced no response");
`endif

endmodule

/* tb/sv/tb_top.sv */
// Testbench for route_table_prefix_match_top: directed and random add, delete and lookup
// streams, each reply checked against a behavioral copy of the routing table.
// Depends on rtpm_pkg, rtpm_if and route_table_prefix_match_top.
module tb_top;
  import rtpm_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int MAX_PROT = 4;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] address;
    logic [31:0] mask;
    logic [31:0] hop;
    logic        prot;
  } route_req_t;

  typedef struct {
    status_t     status;
    kind_t       kind;
    logic [31:0] hop;
  } route_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rtpm_req_if req_ch ();
  rtpm_rsp_if rsp_ch ();

  route_table_prefix_match_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  entry_t       shadow_table [TABLE_DEPTH];
  route_reply_t reply_q [$];
  logic [31:0]  net_pool [4];
  int           mismatch_count = 0;
  bit           req_idle = 1'b1;
  bit           rsp_idle = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic route_req_t route_req(logic [1:0] op, logic [31:0] address,
                                           logic [31:0] mask, logic [31:0] hop, logic prot);
    route_req_t r;
    r = '{op, address, mask, hop, prot};
    return r;
  endfunction

  // Number of live entries, or of live protected entries
  function automatic int count_entries(bit prot_only);
    int n;
    n = 0;
    foreach (shadow_table[s])
      if (shadow_table[s].valid && (!prot_only || shadow_table[s].prot)) n++;
    return n;
  endfunction

  // Apply one request to the shadow table and return the reply it must produce
  function automatic route_reply_t resolve_request(route_req_t r);
    route_reply_t rep;
    int best;
    rep = '{ST_OK, KIND_NONE, 32'h0};
    best = -1;
    case (r.op)
      REQ_ADD: begin
        rep.status = ST_FULL;
        for (int s = 0; s < TABLE_DEPTH; s++) begin
          if (!shadow_table[s].valid) begin
            shadow_table[s] = '{prot: r.prot, valid: 1'b1, hop: r.hop, mask: r.mask,
                                prefix: r.address};
            rep.status = ST_OK;
            break;
          end
        end
      end
      REQ_DEL: begin
        rep.status = ST_NOTFOUND;
        for (int s = 0; s < TABLE_DEPTH; s++) begin
          if (shadow_table[s].valid && shadow_table[s].prefix == r.address &&
              shadow_table[s].mask == r.mask && shadow_table[s].hop == r.hop) begin
            if (shadow_table[s].prot) begin
              rep.status = ST_PROTECTED;
            end else begin
              shadow_table[s] = '0;
              rep.status = ST_OK;
            end
            break;
          end
        end
      end
      REQ_LOOKUP: begin
        // Strictly larger mask wins, so ties stay with the lowest slot
        for (int s = 0; s < TABLE_DEPTH; s++) begin
          if (shadow_table[s].valid &&
              (r.address & shadow_table[s].mask) == shadow_table[s].prefix &&
              (best < 0 || shadow_table[s].mask > shadow_table[best].mask))
            best = s;
        end
        if (best < 0) begin
          rep.status = ST_NOTFOUND;
        end else if (shadow_table[best].hop == 32'h0) begin
          rep.kind = KIND_DIRECT;
        end else begin
          rep.kind = KIND_HOP;
          rep.hop  = shadow_table[best].hop;
        end
      end
      default: ;
    endcase
    return rep;
  endfunction

  // Drive one request from a falling edge and hold it until it is accepted
  task automatic send_request(route_req_t r);
    int gap;
    gap = req_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.req_type      = r.op;
    req_ch.address       = r.address;
    req_ch.prefix_mask   = r.mask;
    req_ch.next_hop_in   = r.hop;
    req_ch.protect_entry = r.prot;
    req_ch.valid         = 1'b1;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    reply_q.insert(reply_q.size(), resolve_request(r));
    @(negedge clk);
  endtask

  initial begin : reply_check
    route_reply_t want;
    int stall;
    rsp_ch.ready = 1'b0;
    forever begin
      stall = rsp_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      if (reply_q.size() == 0) begin
        $display("%0t: unexpected reply: expected none, got status %0d kind %0d hop %h",
                 $time, rsp_ch.status, rsp_ch.route_kind, rsp_ch.next_hop);
        mismatch_count++;
      end else begin
        want = reply_q.pop_front();
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.route_kind !== want.kind) begin
          $display("%0t: route_kind mismatch: expected %0d, got %0d",
                   $time, want.kind, rsp_ch.route_kind);
          mismatch_count++;
        end
        if (rsp_ch.next_hop !== want.hop) begin
          $display("%0t: next_hop mismatch: expected %h, got %h",
                   $time, want.hop, rsp_ch.next_hop);
          mismatch_count++;
        end
      end
      @(negedge clk);
    end
  end

  // Random requests; weights are percent, the remainder goes to unknown request types
  task automatic run_mix(int n, int add_w, int del_w, int look_w);
    route_req_t r;
    entry_t     e;
    int         live [$];
    int         pick;
    int         len;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      r = route_req(REQ_UNKNOWN, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
      live.delete();
      for (int s = 0; s < TABLE_DEPTH; s++)
        if (shadow_table[s].valid) live.insert(live.size(), s);
      if (live.size() > 0) e = shadow_table[live[$urandom_range(0, live.size() - 1)]];
      if (pick < add_w) begin
        r.op = REQ_ADD;
        len = $urandom_range(0, 32);
        r.mask = (len == 0) ? 32'h0 : ~32'h0 << (32 - len);
        if ($urandom_range(0, 7) == 0) r.mask = $urandom;
        // Draw most prefixes from a few networks so that lookups see nested routes
        if ($urandom_range(0, 3) != 0) r.address = net_pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 9) != 0) r.address &= r.mask;
        if ($urandom_range(0, 3) == 0) r.hop = 32'h0;
        r.prot = (count_entries(1) < MAX_PROT) && ($urandom_range(0, 7) == 0);
      end else if (pick < add_w + del_w) begin
        r.op = REQ_DEL;
        if (live.size() > 0 && $urandom_range(0, 9) < 7) begin
          r.address = e.prefix;
          r.mask    = e.mask;
          r.hop     = e.hop;
          if ($urandom_range(0, 9) == 0) r.hop ^= 32'h1 << $urandom_range(0, 31);
        end
      end else if (pick < add_w + del_w + look_w) begin
        r.op = REQ_LOOKUP;
        case ($urandom_range(0, 3))
          0, 1: if (live.size() > 0) r.address = e.prefix | (r.address & ~e.mask);
          2: r.address = net_pool[$urandom_range(0, 3)] ^ (r.address >> $urandom_range(1, 31));
          default: ;
        endcase
      end
      send_request(r);
    end
  endtask

  task automatic test_directed();
    req_idle = 1'b1;
    rsp_idle = 1'b1;
    send_request(route_req(REQ_LOOKUP, 32'h0A01_0203, '1, '1, 1'b1));
    send_request(route_req(REQ_ADD, 32'h0, 32'h0, 32'h0A00_0001, 1'b1));
    send_request(route_req(REQ_ADD, '1, '1, '1, 1'b0));
    send_request(route_req(REQ_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 1'b0));
    send_request(route_req(REQ_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0A00_00FE, 1'b0));
    send_request(route_req(REQ_ADD, 32'hC0A8_0000, 32'hFFFF_00F0, 32'h1234_5678, 1'b0));
    send_request(route_req(REQ_LOOKUP, '1, 32'h0, 32'h0, 1'b0));
    send_request(route_req(REQ_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 1'b0));
    send_request(route_req(REQ_LOOKUP, 32'h0102_0304, 32'h0, 32'h0, 1'b0));
    send_request(route_req(REQ_LOOKUP, 32'hC0A8_AB0F, 32'h0, 32'h0, 1'b0));
    send_request(route_req(REQ_DEL, 32'h0, 32'h0, 32'h0A00_0001, 1'b0));
    send_request(route_req(REQ_DEL, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 1'b0));
    send_request(route_req(REQ_DEL, 32'h0A00_0000, 32'hFF00_0000, 32'h1, 1'b0));
    send_request(route_req(REQ_LOOKUP, 32'h0A01_0203, 32'h0, 32'h0, 1'b0));
    send_request(route_req(REQ_UNKNOWN, '1, '1, '1, 1'b1));
    // Fill the table, then overflow it by one
    while (count_entries(0) < TABLE_DEPTH)
      send_request(route_req(REQ_ADD, $urandom, $urandom, $urandom, 1'b0));
    send_request(route_req(REQ_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 1'b0));
  endtask

  task automatic test_random_churn();
    req_idle = 1'b1;
    rsp_idle = 1'b1;
    run_mix(500, 35, 30, 32);
  endtask

  task automatic test_back_to_back();
    req_idle = 1'b0;
    rsp_idle = 1'b0;
    run_mix(100, 35, 30, 33);
    req_idle = 1'b1;
    run_mix(50, 35, 30, 33);
    req_idle = 1'b0;
    rsp_idle = 1'b1;
    run_mix(50, 35, 30, 33);
  endtask

  task automatic test_fill_drain();
    req_idle = 1'b1;
    rsp_idle = 1'b1;
    repeat (2) begin
      run_mix(60, 85, 5, 8);
      run_mix(60, 5, 85, 8);
    end
  endtask

  initial begin
    req_ch.valid         = 1'b0;
    req_ch.req_type      = REQ_ADD;
    req_ch.address       = 32'h0;
    req_ch.prefix_mask   = 32'h0;
    req_ch.next_hop_in   = 32'h0;
    req_ch.protect_entry = 1'b0;
    foreach (shadow_table[s]) shadow_table[s] = '0;
    foreach (net_pool[k]) net_pool[k] = $urandom;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_churn();
    test_back_to_back();
    test_fill_drain();
    req_ch.valid = 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    // Leave room for a stray extra reply to show up
    repeat (2 * TABLE_DEPTH + 16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* route_table_prefix_match_top.f */
rtl/rtpm_pkg.sv
rtl/rtpm_if.sv
rtl/rtpm_ram.sv
rtl/rtpm_cmp.sv
rtl/route_table_prefix_match_top.sv
tb/sv/tb_top.sv
